// ===== rtl/hec_pkg.sv =====
// ----------------------------------------------------------------------------
// hec_pkg
// Types and constants shared by the hex entry calculator modules.
// ----------------------------------------------------------------------------
package hec_pkg;

  localparam int unsigned DataW   = 64;
  localparam int unsigned NibCnt  = DataW / 4;
  localparam int unsigned NibIdxW = $clog2(NibCnt);
  localparam int unsigned DivCntW = $clog2(DataW);

  typedef enum logic [2:0] {
    OP_KEY   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_SHOW  = 3'd5,
    OP_CLEAR = 3'd6,
    OP_NONE  = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_KEY  = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_RSVD     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SKIP,
    S_SHOW,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       key_char;
    logic [DataW-1:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       digit_char;
    logic             last;
    logic [DataW-1:0] value;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture input item and do the ops that need no iteration
    logic mul_step;  // one 32x16-bit partial product
    logic div_step;  // one restoring division bit
    logic div_done;  // commit quotient or product
    logic nib_dec;   // step the show pointer down
    logic emit;      // load the output register
    logic emit_show; // output register carries a show digit
  } cmd_t;

  typedef struct packed {
    opcode_t          op;
    logic             div_zero;
    logic             acc_zero;
    logic             top_zero;   // nibble at pointer is zero
    logic             nib_first;  // pointer at nibble zero
    logic             cnt_end;    // iteration counter at its end
  } sts_t;

endpackage

// ===== rtl/hec_datapath.sv =====
// ----------------------------------------------------------------------------
// hec_datapath
// Accumulator, shared iterative multiplier and divider, and digit output.
// ----------------------------------------------------------------------------
module hec_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  hec_pkg::in_item_t  in_item,
  input  hec_pkg::cmd_t      cmd,
  output hec_pkg::sts_t      sts,
  output hec_pkg::out_item_t out_item
);
  import hec_pkg::*;

  logic [DataW-1:0]   acc_r, acc_nxt;
  logic [DataW-1:0]   opd_r, opd_nxt;
  logic [DataW-1:0]   work_r, work_nxt;   // product or quotient
  logic [DataW-1:0]   rem_r, rem_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [NibIdxW-1:0] nib_r, nib_nxt;
  opcode_t            op_r, op_nxt;
  status_t            st_r, st_nxt;
  out_item_t          out_r, out_nxt;

  logic [7:0]  k, folded;
  logic [3:0]  digit, nib;
  logic        is_hex;
  logic [15:0] mslice;
  logic [31:0] mhalf;
  logic [47:0] pp;
  logic [DataW:0] rsh, rdiff;

  assign k      = in_item.key_char;
  assign folded = k & 8'hDF;
  assign mslice = opd_r[cnt_r[1:0]*16 +: 16];
  assign mhalf  = cnt_r[2] ? acc_r[63:32] : acc_r[31:0];
  assign pp     = mhalf * mslice;
  assign rsh    = {rem_r, work_r[DataW-1]};
  assign rdiff  = rsh - {1'b0, opd_r};
  assign nib    = acc_r[nib_r*4 +: 4];

  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (k >= 8'h30 && k <= 8'h39) begin
      digit = 4'(k - 8'h30);
    end else if (folded >= 8'h41 && folded <= 8'h46) begin
      digit = 4'(folded - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    opd_nxt  = opd_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    nib_nxt  = nib_r;
    op_nxt   = op_r;
    st_nxt   = st_r;
    out_nxt  = out_r;
    if (cmd.load) begin
      op_nxt   = opcode_t'(in_item.opcode);
      opd_nxt  = in_item.operand;
      st_nxt   = ST_OK;
      cnt_nxt  = '0;
      nib_nxt  = NibIdxW'(NibCnt - 1);
      work_nxt = (opcode_t'(in_item.opcode) == OP_DIV) ? acc_r : '0;
      rem_nxt  = '0;
      unique case (opcode_t'(in_item.opcode))
        OP_KEY: begin
          if (folded == 8'h53) begin
            acc_nxt = '0 - acc_r;
          end else if (!is_hex) begin
            st_nxt = ST_BAD_KEY;
          end else if ((acc_r & 64'h7000000000000000) == '0) begin
            acc_nxt = {acc_r[DataW-5:0], digit};
          end
        end
        OP_ADD:   acc_nxt = acc_r + in_item.operand;
        OP_SUB:   acc_nxt = acc_r - in_item.operand;
        OP_DIV:   if (in_item.operand == '0) st_nxt = ST_DIV_ZERO;
        OP_CLEAR: acc_nxt = '0;
        default: ;
      endcase
    end
    if (cmd.mul_step) begin
      // Product of the low 64 bits: sum of acc[32*i] * opd[16*j] slices.
      // Each step multiplies one 32-bit accumulator half by one 16-bit
      // operand slice; cnt bits 1:0 pick the slice and bit 2 the half.
      if (cnt_r[2]) begin
        work_nxt = work_r + (DataW'({pp, 32'd0}) << (cnt_r[1:0]*16));
      end else begin
        work_nxt = work_r + (DataW'(pp) << (cnt_r[1:0]*16));
      end
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.div_step) begin
      if (!rdiff[DataW]) begin
        rem_nxt = rdiff[DataW-1:0];
      end else begin
        rem_nxt = rsh[DataW-1:0];
      end
      work_nxt = {work_r[DataW-2:0], ~rdiff[DataW]};
      cnt_nxt  = cnt_r + 1'b1;
    end
    if (cmd.div_done) begin
      acc_nxt = work_r;
    end
    if (cmd.nib_dec) begin
      nib_nxt = nib_r - 1'b1;
    end
    if (cmd.emit) begin
      out_nxt.status     = st_r;
      out_nxt.digit_char = '0;
      out_nxt.last       = 1'b1;
      out_nxt.value      = acc_nxt;
      if (cmd.emit_show) begin
        out_nxt.status     = ST_OK;
        out_nxt.digit_char = {4'd0, nib} + ((nib <= 4'd9) ? 8'h30 : 8'h37);
        out_nxt.last       = (nib_r == '0) || (acc_r == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opd_r  <= opd_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    nib_r  <= nib_nxt;
    op_r   <= op_nxt;
    st_r   <= st_nxt;
    out_r  <= out_nxt;
  end

  assign sts.op        = op_r;
  assign sts.div_zero  = (st_r == ST_DIV_ZERO);
  assign sts.acc_zero  = (acc_r == '0);
  assign sts.top_zero  = (nib == 4'd0);
  assign sts.nib_first = (nib_r == '0);
  assign sts.cnt_end   = (op_r == OP_MUL) ? (cnt_r[2:0] == 3'd7) : (cnt_r == '1);
  assign out_item      = out_r;

endmodule

// ===== rtl/hec_ctrl.sv =====
// ----------------------------------------------------------------------------
// hec_ctrl
// Sequencer for the hex entry calculator.
// ----------------------------------------------------------------------------
module hec_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  hec_pkg::sts_t sts,
  output hec_pkg::cmd_t cmd
);
  import hec_pkg::*;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;
  logic   free;

  assign free      = !ov_r || out_ready;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        priority if (sts.op == OP_MUL) begin
          state_nxt = S_MUL;
        end else if (sts.op == OP_DIV && !sts.div_zero) begin
          state_nxt = S_DIV;
        end else if (sts.op == OP_SHOW) begin
          state_nxt = sts.acc_zero ? S_SHOW : S_SKIP;
        end else if (free) begin
          cmd.emit  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.cnt_end) state_nxt = S_SKIP;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_end) state_nxt = S_SKIP;
      end
      S_SKIP: begin
        priority if (sts.op == OP_DIV || sts.op == OP_MUL) begin
          if (free) begin
            cmd.div_done = 1'b1;
            cmd.emit     = 1'b1;
            ov_nxt       = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.top_zero && !sts.nib_first) begin
          cmd.nib_dec = 1'b1;
        end else begin
          state_nxt = S_SHOW;
        end
      end
      S_SHOW: begin
        if (free) begin
          cmd.emit      = 1'b1;
          cmd.emit_show = 1'b1;
          ov_nxt        = 1'b1;
          if (sts.nib_first || sts.acc_zero) state_nxt = S_IDLE;
          else cmd.nib_dec = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

// ===== rtl/hex_entry_calculator.sv =====
// ----------------------------------------------------------------------------
// hex_entry_calculator
// 64-bit hexadecimal keypad calculator.
// ----------------------------------------------------------------------------
// One item is handled at a time. Key, add, subtract, clear and divide by zero
// finish in the load and output states. Multiply runs eight 32x16-bit partial
// products through one shared multiplier. Divide makes one quotient bit
// per cycle in a restoring divider. Show first skips leading zero nibbles,
// then emits one digit per remaining nibble; a zero value shows as a single
// 0 digit. The output register lets a result wait while the next item is
// taken.
module hex_entry_calculator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hec_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hec_pkg::out_item_t out_data
);
  import hec_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hec_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hec_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_data)
  );

endmodule

// ===== verif/tb_hex_entry_calculator.sv =====
// ----------------------------------------------------------------------------
// tb_hex_entry_calculator
// Drives key, arithmetic, show and clear items into the hex entry calculator
// with random gaps on both channels and checks every result against a
// predictor of the 64-bit accumulator held in a small scoreboard.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import hec_pkg::*;

class calc_scoreboard;
  logic [63:0] acc;
  out_item_t   pending[$];
  int          errors;
  int          results_seen;

  function new();
    acc = '0;
    errors = 0;
    results_seen = 0;
  endfunction

  function void push_result(logic [1:0] st, logic [7:0] ch, logic lst);
    out_item_t r;
    r.status = st;
    r.digit_char = ch;
    r.last = lst;
    r.value = acc;
    pending.push_back(r);
  endfunction

  function void note_input(in_item_t it);
    logic [7:0] k;
    logic [7:0] folded;
    logic [3:0] dig;
    logic [3:0] nib;
    logic [1:0] st;
    int top;
    st = ST_OK;
    case (opcode_t'(it.opcode))
      OP_KEY: begin
        k = it.key_char;
        folded = k & 8'hDF;
        if (folded == "S") begin
          acc = -acc;
        end else if (k >= "0" && k <= "9" || folded >= "A" && folded <= "F") begin
          dig = (k <= "9") ? 4'(k - 8'h30) : 4'(folded - 8'h37);
          if ((acc & 64'h7000_0000_0000_0000) == 0) acc = {acc[59:0], dig};
        end else begin
          st = ST_BAD_KEY;
        end
      end
      OP_ADD: acc = acc + it.operand;
      OP_SUB: acc = acc - it.operand;
      OP_MUL: acc = acc * it.operand;
      OP_DIV: begin
        if (it.operand == 0) st = ST_DIV_ZERO;
        else acc = acc / it.operand;
      end
      OP_SHOW: begin
        top = 16;
        while (top > 1 && acc[(top-1)*4 +: 4] == 0) top--;
        for (int i = top; i > 0; i--) begin
          nib = acc[(i-1)*4 +: 4];
          push_result(ST_OK, (nib <= 9) ? 8'h30 + nib : 8'h37 + nib, i == 1);
        end
        return;
      end
      OP_CLEAR: acc = '0;
      default: ;
    endcase
    push_result(st, 8'h00, 1'b1);
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.digit_char !== want.digit_char)
      report($sformatf("digit %h, expected %h", got.digit_char, want.digit_char));
    if (got.last !== want.last)
      report($sformatf("last %b, expected %b", got.last, want.last));
    if (got.value !== want.value)
      report($sformatf("value %h, expected %h", got.value, want.value));
  endtask
endclass

module tb_hex_entry_calculator;
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  calc_scoreboard board;
  int  cycles;
  int  items_sent;

  hex_entry_calculator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = 64'($urandom_range(1, 20));
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  task automatic send_item(opcode_t op, logic [7:0] ch, logic [63:0] opnd);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{opcode: op, key_char: ch, operand: opnd};
    do @(posedge clk); while (!in_ready);
    board.note_input(in_data);
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (gap_len()) @(negedge clk);
  endtask

  task automatic send_key(logic [7:0] ch);
    send_item(OP_KEY, ch, '0);
  endtask

  function automatic logic [7:0] hex_key();
    string hx;
    hx = "0123456789ABCDEFabcdef";
    return hx[$urandom_range(0, 21)];
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_hex_entry_calculator: errors");
      $finish;
    end
  end

  initial begin
    int op;
    int wait_cycles;
    board = new();
    cycles = 0;
    items_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero show, digits, sign, bad keys, every operation.
    send_item(OP_SHOW, 8'h00, '0);
    send_key("0"); send_key("9"); send_key("a"); send_key("F");
    send_key("G"); send_key(8'hFF); send_key(8'h00);
    send_item(OP_SHOW, 8'h00, '0);
    send_key("s"); send_item(OP_SHOW, 8'h00, '0);
    send_key("S");
    send_item(OP_ADD, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_SUB, 8'h00, 64'h8000_0000_0000_0000);
    send_key("7");
    send_item(OP_MUL, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_DIV, 8'h00, '0);
    send_item(OP_DIV, 8'h00, 64'd3);
    send_item(OP_DIV, 8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_NONE, 8'hA5, 64'h1234);
    send_item(OP_CLEAR, 8'h00, '0);
    send_item(OP_ADD, 8'h00, 64'h8123_4567_89AB_CDEF);
    send_key("1");
    send_item(OP_SHOW, 8'h00, '0);

    // Random: digit entry runs, random and sign keys, arithmetic, show, clear and no-op.
    while (items_sent < 245) begin
      op = $urandom_range(0, 99);
      if (op < 20) begin
        repeat ($urandom_range(1, 17)) send_key(hex_key());
      end else if (op < 30) begin
        send_key(8'($urandom_range(0, 255)));
      end else if (op < 35) begin
        send_key($urandom_range(0, 1) ? "S" : "s");
      end else if (op < 75) begin
        send_item(opcode_t'($urandom_range(1, 4)), 8'($urandom_range(0, 255)), rand64());
      end else if (op < 90) begin
        send_item(OP_SHOW, 8'($urandom_range(0, 255)), rand64());
      end else begin
        send_item(opcode_t'($urandom_range(6, 7)), 8'($urandom_range(0, 255)), rand64());
      end
    end

    while (board.pending.size() != 0) @(posedge clk);
    wait_cycles = 200;
    repeat (wait_cycles) @(posedge clk);
    $display("Sent %0d items covering keys, arithmetic, show and clear;", items_sent);
    $display("checked %0d results with random gaps on both sides.", board.results_seen);
    if (board.errors == 0) begin
      $display("tb_hex_entry_calculator: clean");
    end else begin
      $display("tb_hex_entry_calculator: errors");
    end
    $finish;
  end
endmodule
